### hdl/sssp_pkg.sv
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared types and constants for the shortest-path unit.
// ----------------------------------------------------------------------------
package sssp_pkg;

    localparam int NV     = 8;
    localparam int VB     = 3;
    localparam int WB     = 16;
    localparam int DB     = 24;
    localparam int WMB    = 6;

    localparam logic [WB-1:0] NO_EDGE  = {WB{1'b1}};
    localparam logic [DB-1:0] DIST_MAX = {DB{1'b1}};

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_RUN   = 1'b1;

    typedef struct packed {
        logic          mode;
        logic [VB-1:0] row;
        logic [VB-1:0] col;
        logic [WB-1:0] weight;
        logic [VB-1:0] source;
    } in_item_t;

    typedef struct packed {
        logic [VB-1:0] vertex;
        logic [DB-1:0] distance;
        logic [VB-1:0] predecessor;
        logic          reachable;
        logic          last;
    } out_item_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic          init;
        logic          relax;
        logic          finish;
        logic [VB-1:0] src;
        logic [VB-1:0] pick;
        logic [DB-1:0] pick_dist;
        logic [WB-1:0] w;
        logic [VB-1:0] w_col;
    } cell_cmd_t;

    // Running minimum passed along the chain.
    typedef struct packed {
        logic          found;
        logic [VB-1:0] idx;
        logic [DB-1:0] min_dist;
    } min_link_t;

endpackage

### hdl/sssp_cell.sv
// ----------------------------------------------------------------------------
// sssp_cell
// One vertex: holds distance, predecessor and flags; relaxes and joins the
// minimum chain.
// ----------------------------------------------------------------------------
module sssp_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [sssp_pkg::VB-1:0] idx,
    input  sssp_pkg::cell_cmd_t     cmd,
    input  sssp_pkg::min_link_t     min_in,
    output sssp_pkg::min_link_t     min_out,
    output logic [sssp_pkg::DB-1:0] best_dist,
    output logic [sssp_pkg::VB-1:0] pred,
    output logic                    reached
);
    logic [sssp_pkg::DB-1:0] dist_reg;
    logic [sssp_pkg::VB-1:0] pred_reg;
    logic                    reached_reg;
    logic                    fin_reg;
    logic [sssp_pkg::DB:0]   sum;
    logic [sssp_pkg::DB-1:0] cand;
    logic                    hit;
    logic                    edge_ok;

    assign hit     = (cmd.w_col == idx);
    assign edge_ok = (cmd.w != sssp_pkg::NO_EDGE);
    assign sum     = {1'b0, cmd.pick_dist} + (sssp_pkg::DB+1)'(cmd.w);
    assign cand    = sum[sssp_pkg::DB] ? sssp_pkg::DIST_MAX : sum[sssp_pkg::DB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg    <= '0;
            pred_reg    <= '0;
            reached_reg <= 1'b0;
            fin_reg     <= 1'b0;
        end
        else if (cmd.init && hit)
        begin
            fin_reg <= (idx == cmd.src);
            if (idx == cmd.src)
            begin
                reached_reg <= 1'b1;
                dist_reg    <= '0;
                pred_reg    <= cmd.src;
            end
            else if (edge_ok)
            begin
                reached_reg <= 1'b1;
                dist_reg    <= sssp_pkg::DB'(cmd.w);
                pred_reg    <= cmd.src;
            end
            else
            begin
                reached_reg <= 1'b0;
                dist_reg    <= '0;
                pred_reg    <= '0;
            end
        end
        else if (cmd.finish && cmd.pick == idx)
        begin
            fin_reg <= 1'b1;
        end
        else if (cmd.relax && hit && !fin_reg && edge_ok &&
                 (!reached_reg || cand < dist_reg))
        begin
            reached_reg <= 1'b1;
            dist_reg    <= cand;
            pred_reg    <= cmd.pick;
        end
    end

    always_comb
    begin
        min_out = min_in;
        if (!fin_reg && reached_reg && (!min_in.found || dist_reg < min_in.min_dist))
        begin
            min_out.found    = 1'b1;
            min_out.idx      = idx;
            min_out.min_dist = dist_reg;
        end
    end

    assign best_dist = dist_reg;
    assign pred      = pred_reg;
    assign reached   = reached_reg;
endmodule

### hdl/single_source_shortest_path_unit.sv
// ----------------------------------------------------------------------------
// single_source_shortest_path_unit
// Dijkstra over an 8x8 weight matrix, one cell per vertex.
// ----------------------------------------------------------------------------
// channel | direction | payload     | handshake
// in      | input     | in_item_t   | in_valid / in_stall
// out     | output    | out_item_t  | out_valid / out_stall
// A write transaction updates the matrix as it is taken. Run: an init pass
// (one matrix read per vertex), then per round a pick step (which first lets
// the last read land) and a relax pass over the picked row, at most 7 rounds,
// then a closing pick and 8 result transactions.
// The matrix memory reads one word a cycle; that port sets the run length.
// After reset a clearing pass fills all 64 matrix words with no-edge before input.
// Output stalls hold the result register; input stalls until the run ends.
module single_source_shortest_path_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sssp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sssp_pkg::out_item_t  out_data
);
    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_INIT  = 3'd2;
    localparam logic [2:0] ST_PICK  = 3'd3;
    localparam logic [2:0] ST_RELAX = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [sssp_pkg::WB-1:0]  mem [sssp_pkg::NV*sssp_pkg::NV];
    logic [sssp_pkg::WB-1:0]  rd_reg;
    logic [2:0]               st_reg, st_next;
    logic [sssp_pkg::WMB:0]   cnt_reg, cnt_next;
    logic [sssp_pkg::VB-1:0]  src_reg, src_next;
    logic [sssp_pkg::VB-1:0]  pick_reg, pick_next;
    logic [sssp_pkg::VB-1:0]  col_reg;
    logic                     rd_v_reg;
    logic                     rd_init_reg;
    logic                     wr_en;
    logic [sssp_pkg::WMB-1:0] wr_addr, rd_addr;
    logic [sssp_pkg::WB-1:0]  wr_data;
    logic                     rd_en;
    logic                     out_valid_reg;
    sssp_pkg::out_item_t      out_reg;
    sssp_pkg::cell_cmd_t      cmd;
    sssp_pkg::min_link_t      link [sssp_pkg::NV+1];
    logic [sssp_pkg::DB-1:0]  dist_v [sssp_pkg::NV];
    logic [sssp_pkg::VB-1:0]  pred_v [sssp_pkg::NV];
    logic                     reach_v [sssp_pkg::NV];
    logic [sssp_pkg::VB-1:0]  ecnt;
    logic                     accept;
    logic                     emit_fire;

    assign in_stall  = (st_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign ecnt      = cnt_reg[sssp_pkg::VB-1:0];
    assign emit_fire = (st_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[sssp_pkg::WMB-1:0];
        wr_data = sssp_pkg::NO_EDGE;
        if (st_reg == ST_CLR)
            wr_en = 1'b1;
        else if (accept && in_data.mode == sssp_pkg::MODE_WRITE)
        begin
            wr_en   = 1'b1;
            wr_addr = {in_data.row, in_data.col};
            wr_data = in_data.weight;
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {src_reg, ecnt};
        if (st_reg == ST_INIT)
            rd_en = 1'b1;
        else if (st_reg == ST_RELAX)
        begin
            rd_en   = 1'b1;
            rd_addr = {pick_reg, ecnt};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg  <= mem[rd_addr];
        col_reg <= ecnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg    <= 1'b0;
            rd_init_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg    <= rd_en;
            rd_init_reg <= (st_reg == ST_INIT);
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.init      = rd_v_reg && rd_init_reg;
        cmd.relax     = rd_v_reg && !rd_init_reg;
        cmd.finish    = (st_reg == ST_PICK) && link[sssp_pkg::NV].found && !rd_v_reg;
        cmd.src       = src_reg;
        cmd.pick      = cmd.finish ? link[sssp_pkg::NV].idx : pick_reg;
        cmd.pick_dist = dist_v[pick_reg];
        cmd.w         = rd_reg;
        cmd.w_col     = col_reg;
    end

    assign link[0] = '0;

    for (genvar g = 0; g < sssp_pkg::NV; g++)
    begin : g_cell
        sssp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (sssp_pkg::VB'(g)),
            .cmd       (cmd),
            .min_in    (link[g]),
            .min_out   (link[g+1]),
            .best_dist (dist_v[g]),
            .pred      (pred_v[g]),
            .reached   (reach_v[g])
        );
    end

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        pick_next = pick_reg;
        case (st_reg)
            ST_CLR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (sssp_pkg::WMB+1)'(sssp_pkg::NV*sssp_pkg::NV-1))
                begin
                    cnt_next = '0;
                    st_next  = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && in_data.mode == sssp_pkg::MODE_RUN)
                begin
                    src_next = in_data.source;
                    cnt_next = '0;
                    st_next  = ST_INIT;
                end
            end
            ST_INIT, ST_RELAX:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (ecnt == sssp_pkg::VB'(sssp_pkg::NV-1))
                begin
                    cnt_next = '0;
                    st_next  = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (!rd_v_reg)
                begin
                    cnt_next = '0;
                    if (link[sssp_pkg::NV].found)
                    begin
                        pick_next = link[sssp_pkg::NV].idx;
                        st_next   = ST_RELAX;
                    end
                    else
                        st_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (ecnt == sssp_pkg::VB'(sssp_pkg::NV-1))
                    begin
                        cnt_next = '0;
                        st_next  = ST_IDLE;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLR;
            cnt_reg       <= '0;
            src_reg       <= '0;
            pick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            src_reg  <= src_next;
            pick_reg <= pick_next;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_reg.vertex      <= ecnt;
            out_reg.reachable   <= reach_v[ecnt];
            out_reg.distance    <= reach_v[ecnt] ? dist_v[ecnt] : '0;
            out_reg.predecessor <= reach_v[ecnt] ? pred_v[ecnt] : '0;
            out_reg.last        <= (ecnt == sssp_pkg::VB'(sssp_pkg::NV-1));
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(st_reg == ST_EMIT))
        else $error("result outside emit");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
endmodule
